// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, idle while reset is low
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/epool_pkg.sv -----
// ----------------------------------------------------------------------------
// epool_pkg
// Shared widths, codes and types of the entry pool.
// ----------------------------------------------------------------------------
package epool_pkg;

    localparam int ENTRIES = 512;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int LINK_W  = IDX_W + 1;
    localparam int CNT_W   = LINK_W;
    localparam int TIME_W  = 31;
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(ENTRIES);

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_SWEEP = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef struct packed {
        t_action           action;
        logic [IDX_W-1:0]  handle;
        logic [TIME_W-1:0] end_time;
        logic [TIME_W-1:0] now_time;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0] granted_handle;
        logic             evicted;
        logic [IDX_W-1:0] evicted_handle;
        logic             error;
        logic [CNT_W-1:0] freed_count;
        logic [CNT_W-1:0] active_count;
    } t_result;

    // handshake between the command queue and the sequencer
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_out;

endpackage

// ----- rtl/epool_front.sv -----
// ----------------------------------------------------------------------------
// epool_front
// Accepts input transfers, decodes the action and holds them in a two-entry
// queue for the sequencer.
// ----------------------------------------------------------------------------
module epool_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_action,
    input  logic [epool_pkg::IDX_W-1:0]  i_handle,
    input  logic [epool_pkg::TIME_W-1:0] i_end_time,
    input  logic [epool_pkg::TIME_W-1:0] i_now_time,
    output epool_pkg::t_queue_out      o_q,
    input  logic                       i_pop
);

    epool_pkg::t_cmd r_buf [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    epool_pkg::t_cmd w_cmd;
    logic            w_push;
    logic            w_pop;

    // every 2-bit code is a defined action, the spare one being the no-op
    always_comb begin
        w_cmd.handle   = i_handle;
        w_cmd.end_time = i_end_time;
        w_cmd.now_time = i_now_time;
        w_cmd.action   = epool_pkg::t_action'(i_action);
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign w_pop     = i_pop && (r_cnt != 2'd0);
    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.cmd   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// ----- rtl/epool_back.sv -----
// ----------------------------------------------------------------------------
// epool_back
// Sequencer that carries out allocate, free and sweep on the link memories
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module epool_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  epool_pkg::t_queue_out         i_q,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output epool_pkg::t_result            o_res
);

    typedef enum logic [14:0] {
        S_CLEAR  = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_F_WAIT = 15'b000000000000100,
        S_F_CHK  = 15'b000000000001000,
        S_A_WAIT = 15'b000000000010000,
        S_A_LINK = 15'b000000000100000,
        S_A_BACK = 15'b000000001000000,
        S_S_CHK  = 15'b000000010000000,
        S_S_WAIT = 15'b000000100000000,
        S_S_EVAL = 15'b000001000000000,
        S_R_WAIT = 15'b000010000000000,
        S_R_LINK = 15'b000100000000000,
        S_R_PUSH = 15'b001000000000000,
        S_DONE   = 15'b010000000000000,
        S_SPARE  = 15'b100000000000000
    } t_state;

    logic [epool_pkg::LINK_W-1:0] m_next   [epool_pkg::ENTRIES];
    logic [epool_pkg::LINK_W-1:0] m_prev   [epool_pkg::ENTRIES];
    logic                         m_active [epool_pkg::ENTRIES];
    logic [epool_pkg::TIME_W-1:0] m_expiry [epool_pkg::ENTRIES];

    t_state                       r_state, n_state;
    epool_pkg::t_cmd              r_cmd;
    epool_pkg::t_result           r_res;
    epool_pkg::t_result           r_out;
    logic                         r_out_valid;
    logic [epool_pkg::IDX_W-1:0]  r_clr;
    logic [epool_pkg::IDX_W-1:0]  r_rd_addr;
    logic [epool_pkg::IDX_W-1:0]  r_h;
    logic [epool_pkg::LINK_W-1:0] r_cur;
    logic [epool_pkg::LINK_W-1:0] r_tmp;
    logic [epool_pkg::LINK_W-1:0] r_free_top;
    logic [epool_pkg::LINK_W-1:0] r_newest;
    logic [epool_pkg::LINK_W-1:0] r_oldest;
    logic [epool_pkg::LINK_W-1:0] r_live;

    logic [epool_pkg::LINK_W-1:0] r_next_q;
    logic [epool_pkg::LINK_W-1:0] r_prev_q;
    logic                         r_active_q;
    logic [epool_pkg::TIME_W-1:0] r_expiry_q;

    logic                         w_next_we, w_prev_we, w_act_we, w_exp_we;
    logic [epool_pkg::IDX_W-1:0]  w_next_a, w_prev_a, w_act_a;
    logic [epool_pkg::LINK_W-1:0] w_next_d, w_prev_d;
    logic                         w_act_d;
    logic                         w_out_load;
    logic                         w_evict;
    epool_pkg::t_result           w_res_out;

    // memory reads, registered
    always_ff @(posedge i_clk) begin
        r_next_q   <= m_next[r_rd_addr];
        r_prev_q   <= m_prev[r_rd_addr];
        r_active_q <= m_active[r_rd_addr];
        r_expiry_q <= m_expiry[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_next_we) m_next[w_next_a]   <= w_next_d;
        if (w_prev_we) m_prev[w_prev_a]   <= w_prev_d;
        if (w_act_we)  m_active[w_act_a]  <= w_act_d;
        if (w_exp_we)  m_expiry[r_h]      <= r_cmd.end_time;
    end

    // write ports: one address per memory per state
    always_comb begin
        w_next_we = 1'b0;
        w_next_a  = r_h;
        w_next_d  = r_free_top;
        w_prev_we = 1'b0;
        w_prev_a  = r_h;
        w_prev_d  = epool_pkg::NIL_LINK;
        w_act_we  = 1'b0;
        w_act_a   = r_h;
        w_act_d   = 1'b0;
        w_exp_we  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_next_we = 1'b1;
                w_next_a  = r_clr;
                w_next_d  = {1'b0, r_clr} + epool_pkg::LINK_W'(1);
                w_act_we  = 1'b1;
                w_act_a   = r_clr;
            end
            S_R_LINK: begin
                // unlink: newer.next = older, older.prev = newer
                w_next_we = (r_prev_q != epool_pkg::NIL_LINK);
                w_next_a  = r_prev_q[epool_pkg::IDX_W-1:0];
                w_next_d  = r_next_q;
                w_prev_we = (r_next_q != epool_pkg::NIL_LINK);
                w_prev_a  = r_next_q[epool_pkg::IDX_W-1:0];
                w_prev_d  = r_prev_q;
                w_act_we  = 1'b1;
            end
            S_R_PUSH: begin
                w_next_we = 1'b1;
            end
            S_A_LINK: begin
                w_next_we = 1'b1;
                w_next_d  = r_newest;
                w_prev_we = 1'b1;
                w_act_we  = 1'b1;
                w_act_d   = 1'b1;
                w_exp_we  = 1'b1;
            end
            S_A_BACK: begin
                w_prev_we = (r_tmp != epool_pkg::NIL_LINK);
                w_prev_a  = r_tmp[epool_pkg::IDX_W-1:0];
                w_prev_d  = {1'b0, r_h};
            end
            default: ;
        endcase
    end

    assign o_pop      = (r_state == S_IDLE) && i_q.valid;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_ready);
    assign w_evict    = (r_free_top == epool_pkg::NIL_LINK) &&
                        (i_q.cmd.action == epool_pkg::ACT_ALLOC);
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;

    always_comb begin
        w_res_out              = r_res;
        w_res_out.active_count = r_live;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (&r_clr) n_state = S_IDLE;
            S_IDLE: begin
                if (i_q.valid) begin
                    unique case (i_q.cmd.action)
                        epool_pkg::ACT_ALLOC:
                            n_state = (r_free_top == epool_pkg::NIL_LINK) ? S_R_WAIT
                                                                          : S_A_WAIT;
                        epool_pkg::ACT_FREE:  n_state = S_F_WAIT;
                        epool_pkg::ACT_SWEEP: n_state = S_S_CHK;
                        default:              n_state = S_DONE;
                    endcase
                end
            end
            S_F_WAIT: n_state = S_F_CHK;
            S_F_CHK:  n_state = r_active_q ? S_R_LINK : S_DONE;
            S_A_WAIT: n_state = S_A_LINK;
            S_A_LINK: n_state = S_A_BACK;
            S_A_BACK: n_state = S_DONE;
            S_S_CHK:  n_state = (r_cur == epool_pkg::NIL_LINK) ? S_DONE : S_S_WAIT;
            S_S_WAIT: n_state = S_S_EVAL;
            S_S_EVAL: n_state = (r_cmd.now_time >= r_expiry_q) ? S_R_LINK : S_S_CHK;
            S_R_WAIT: n_state = S_R_LINK;
            S_R_LINK: n_state = S_R_PUSH;
            S_R_PUSH: begin
                unique case (r_cmd.action)
                    epool_pkg::ACT_ALLOC: n_state = S_A_WAIT;
                    epool_pkg::ACT_SWEEP: n_state = S_S_CHK;
                    default:              n_state = S_DONE;
                endcase
            end
            S_DONE:   if (w_out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_free_top  <= '0;
            r_newest    <= epool_pkg::NIL_LINK;
            r_oldest    <= epool_pkg::NIL_LINK;
            r_live      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + epool_pkg::IDX_W'(1);
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_R_LINK: begin
                    if (r_prev_q == epool_pkg::NIL_LINK) r_newest <= r_next_q;
                    if (r_next_q == epool_pkg::NIL_LINK) r_oldest <= r_prev_q;
                    if (r_live != '0) r_live <= r_live - epool_pkg::LINK_W'(1);
                end
                S_R_PUSH: r_free_top <= {1'b0, r_h};
                S_A_LINK: begin
                    r_free_top <= r_next_q;
                    if (r_newest == epool_pkg::NIL_LINK) r_oldest <= {1'b0, r_h};
                    r_newest <= {1'b0, r_h};
                    r_live   <= r_live + epool_pkg::LINK_W'(1);
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_cmd <= i_q.cmd;
                r_res <= '{granted_handle: '0,
                           evicted:        w_evict,
                           evicted_handle: w_evict ? r_oldest[epool_pkg::IDX_W-1:0] : '0,
                           error:          1'b0,
                           freed_count:    '0,
                           active_count:   '0};
                r_cur <= r_oldest;
                if (i_q.cmd.action == epool_pkg::ACT_FREE) begin
                    r_rd_addr <= i_q.cmd.handle;
                    r_h       <= i_q.cmd.handle;
                end else if (r_free_top == epool_pkg::NIL_LINK) begin
                    // pool full: evict the oldest first
                    r_rd_addr <= r_oldest[epool_pkg::IDX_W-1:0];
                    r_h       <= r_oldest[epool_pkg::IDX_W-1:0];
                end else begin
                    r_rd_addr <= r_free_top[epool_pkg::IDX_W-1:0];
                    r_h       <= r_free_top[epool_pkg::IDX_W-1:0];
                end
            end
            S_F_CHK: if (!r_active_q) r_res.error <= 1'b1;
            S_S_CHK: begin
                r_rd_addr <= r_cur[epool_pkg::IDX_W-1:0];
                r_h       <= r_cur[epool_pkg::IDX_W-1:0];
            end
            S_S_EVAL: r_cur <= r_prev_q;
            S_R_LINK: begin
                if (r_cmd.action == epool_pkg::ACT_SWEEP) begin
                    r_res.freed_count <= r_res.freed_count + epool_pkg::CNT_W'(1);
                end
            end
            S_R_PUSH: r_rd_addr <= r_h;
            S_A_LINK: begin
                r_tmp                <= r_newest;
                r_res.granted_handle <= r_h;
            end
            default: ;
        endcase
        if (w_out_load) begin
            r_out <= w_res_out;
        end
    end

endmodule

// ----- rtl/entry_pool_with_oldest_eviction.sv -----
// ----------------------------------------------------------------------------
// entry_pool_with_oldest_eviction
// Pool of 512 entry handles with a LIFO free stack and an age-ordered list.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the link memory, and the
// sequencer takes no item until it ends. One item is carried out at a time
// by a sequencer working on link memories with one write and one registered
// read per cycle; a two-entry queue in front accepts while it has room.
// An allocate on a full pool first evicts the oldest entry; a free of an
// inactive handle only flags an error; a sweep walks the age list from the
// oldest entry to the newest and frees each entry that has expired.
module entry_pool_with_oldest_eviction (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_action,
    input  logic [epool_pkg::IDX_W-1:0]   i_handle,
    input  logic [epool_pkg::TIME_W-1:0]  i_end_time,
    input  logic [epool_pkg::TIME_W-1:0]  i_now_time,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [epool_pkg::IDX_W-1:0]   o_granted_handle,
    output logic                          o_evicted,
    output logic [epool_pkg::IDX_W-1:0]   o_evicted_handle,
    output logic                          o_error,
    output logic [epool_pkg::CNT_W-1:0]   o_freed_count,
    output logic [epool_pkg::CNT_W-1:0]   o_active_count
);

    epool_pkg::t_queue_out w_q;
    logic                  w_pop;
    epool_pkg::t_result    w_res;

    epool_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_action   (i_action),
        .i_handle   (i_handle),
        .i_end_time (i_end_time),
        .i_now_time (i_now_time),
        .o_q        (w_q),
        .i_pop      (w_pop)
    );

    epool_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (w_q),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (w_res)
    );

    assign o_granted_handle = w_res.granted_handle;
    assign o_evicted        = w_res.evicted;
    assign o_evicted_handle = w_res.evicted_handle;
    assign o_error          = w_res.error;
    assign o_freed_count    = w_res.freed_count;
    assign o_active_count   = w_res.active_count;

endmodule

// ----- rtl/epool_checker.sv -----
// ----------------------------------------------------------------------------
// epool_checker
// Port-level checks of the entry pool, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epool_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [epool_pkg::IDX_W-1:0]   o_granted_handle,
    input logic                          o_evicted,
    input logic                          o_error,
    input logic [epool_pkg::CNT_W-1:0]   o_freed_count,
    input logic [epool_pkg::CNT_W-1:0]   o_active_count
);

    // a stalled result holds its count
    `AST_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_active_count))
    // an eviction only happens on a full pool
    `AST_IMPL(a_evict_full, i_clk, i_rst_n, o_valid && o_evicted, o_active_count == epool_pkg::CNT_W'(epool_pkg::ENTRIES))
    // a rejected free reports nothing else
    `AST_IMPL(a_err_clean, i_clk, i_rst_n, o_valid && o_error, !o_evicted && o_granted_handle == '0 && o_freed_count == '0)
    // never more active entries than the pool holds
    `AST_IMPL(a_count_rng, i_clk, i_rst_n, o_valid, o_active_count <= epool_pkg::CNT_W'(epool_pkg::ENTRIES))

endmodule

bind entry_pool_with_oldest_eviction epool_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_granted_handle (o_granted_handle),
    .o_evicted        (o_evicted),
    .o_error          (o_error),
    .o_freed_count    (o_freed_count),
    .o_active_count   (o_active_count)
);
